// ----- src/icb_pkg.sv -----
// Shared types and constants for the intermediate correlation bisection unit.
// No dependencies; every other file but icb_fifo and icb_mul uses this package.
`timescale 1ns / 1ps

package icb_pkg;

  // Fixed field widths of the external item formats.
  localparam int IN_W    = 32;
  localparam int TGT_W   = 25;
  localparam int CFG_W   = 24;
  localparam int LIM_W   = 8;
  localparam int RHO_W   = 25;
  localparam int IO_FRAC = 24;

  // Configuration register indexes.
  localparam int CIDX_W = 2;
  localparam logic [CIDX_W-1:0] REG_BRACKET  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_CORR_TOL = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ITER_LIM = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] BRACKET_RST  = 24'd16609444;
  localparam logic [CFG_W-1:0] CORR_TOL_RST = 24'd17;
  localparam logic [LIM_W-1:0] ITER_LIM_RST = 8'd100;

  // Word slots of a converted command in the front queue.
  localparam int CMD_N   = 9;
  localparam int CMD_LL  = 0;
  localparam int CMD_LQ  = 1;
  localparam int CMD_LC  = 2;
  localparam int CMD_RL  = 3;
  localparam int CMD_RQ  = 4;
  localparam int CMD_RC  = 5;
  localparam int CMD_TGT = 6;
  localparam int CMD_BND = 7;
  localparam int CMD_TOL = 8;

  // Sequencer phase counter: seven phases per multiply schedule.
  localparam int PH_W = 3;
  localparam logic [PH_W-1:0] PH_LAST = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LIN,
    ST_EVAL,
    ST_POST,
    ST_ITER,
    ST_DONE
  } icb_state_t;

  // Which point the current residual evaluation belongs to.
  typedef enum logic [1:0] {
    KIND_LO,
    KIND_HI,
    KIND_MID
  } icb_kind_t;

  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic                    status;
    logic                    limit_reached;
  } icb_result_t;

endpackage

// ----- src/intermediate_correlation_bisection_unit.sv -----
// Top level of the intermediate correlation bisection unit: configuration
// registers, front queue, solver and result queue. Depends on icb_pkg,
// icb_front, icb_solver and icb_fifo.
//
//   port group   direction  handshake            payload
//   in_*         in         in_push / in_full    six cubic coefficients, target
//   out_*        out        out_pop / out_empty  rho, status, limit_reached
//   cfg_*        in         cfg_we               cfg_index, cfg_data
//
// The solver runs n bisection steps per item, where n is at most
// iteration_limit. Each step is set by the chain of three dependent
// products through the shared two-stage multiplier.
// Up to two items wait in the front queue and two results in the output queue;
// the solver works on one item at a time. Reset is synchronous, active low,
// and empties both queues; a full output queue stalls the solver.
`timescale 1ns / 1ps

module intermediate_correlation_bisection_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_lin,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_quad,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_cube,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_lin,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_quad,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_cube,
  input  logic signed [icb_pkg::TGT_W-1:0]  in_goal_corr,
  output logic                              out_empty,
  input  logic                              out_pop,
  output logic signed [icb_pkg::RHO_W-1:0]  out_rho,
  output logic                              out_status,
  output logic                              out_limit_reached,
  input  logic                              cfg_we,
  input  logic [icb_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [icb_pkg::CFG_W-1:0]         cfg_data
);

  import icb_pkg::*;

  localparam int RW = $bits(icb_result_t);

  logic [CFG_W-1:0] bracket_half_r, corr_tol_r;
  logic [LIM_W-1:0] iter_limit_r;

  logic                              cmd_valid, cmd_pop;
  logic [CMD_N-1:0][WORD_BITS-1:0]   cmd_data;
  logic [LIM_W-1:0]                  cmd_limit;
  logic                              res_full, res_push;
  icb_result_t                       res_data, out_item;
  logic [RW-1:0]                     out_bits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bracket_half_r <= BRACKET_RST;
      corr_tol_r     <= CORR_TOL_RST;
      iter_limit_r   <= ITER_LIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BRACKET:  bracket_half_r <= cfg_data;
        REG_CORR_TOL: corr_tol_r     <= cfg_data;
        REG_ITER_LIM: iter_limit_r   <= cfg_data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  icb_front #(
    .W(WORD_BITS),
    .F(FRAC_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .left_lin    (in_left_lin),
    .left_quad   (in_left_quad),
    .left_cube   (in_left_cube),
    .right_lin   (in_right_lin),
    .right_quad  (in_right_quad),
    .right_cube  (in_right_cube),
    .goal_corr   (in_goal_corr),
    .bracket_half(bracket_half_r),
    .corr_tol    (corr_tol_r),
    .iter_limit  (iter_limit_r),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd_data    (cmd_data),
    .cmd_limit   (cmd_limit)
  );

  icb_solver #(
    .W(WORD_BITS),
    .F(FRAC_BITS)
  ) u_solver (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd_pop  (cmd_pop),
    .cmd_data (cmd_data),
    .cmd_limit(cmd_limit),
    .res_full (res_full),
    .res_push (res_push),
    .res_data (res_data)
  );

  // Result queue toward the consumer.
  icb_fifo #(
    .WIDTH(RW),
    .DEPTH(2)
  ) u_res_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_push),
    .push_data(res_data),
    .full     (res_full),
    .pop      (out_pop),
    .pop_data (out_bits),
    .empty    (out_empty)
  );

  assign out_item          = icb_result_t'(out_bits);
  assign out_rho           = out_item.rho;
  assign out_status        = out_item.status;
  assign out_limit_reached = out_item.limit_reached;

endmodule

// ----- src/icb_fifo.sv -----
// Small register-based first-in first-out queue used on both sides of the solver.
// Depends on nothing; width and depth are parameters.
`timescale 1ns / 1ps

module icb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/icb_mul.sv -----
// Two-stage saturating fixed-point multiplier, truncating toward zero.
// Depends on nothing; word and fraction widths are parameters.
`timescale 1ns / 1ps

module icb_mul #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                clk,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int HW = W - H;
  localparam int PW = 2 * W;

  logic [W-1:0]    ma, mb;
  logic [W+H-1:0]  pl_nxt, pl_r;
  logic [W+HW-1:0] phi_nxt, phi_r;
  logic            neg_r;
  logic [PW-1:0]   full, q, lim;
  logic [W-1:0]    r;
  logic signed [W-1:0] p_nxt, p_r;

  // Stage one: magnitudes and two partial products over the halves of b.
  always_comb begin
    ma      = a[W-1] ? (~a + 1'b1) : a;
    mb      = b[W-1] ? (~b + 1'b1) : b;
    pl_nxt  = (W+H)'(ma) * (W+H)'(mb[H-1:0]);
    phi_nxt = (W+HW)'(ma) * (W+HW)'(mb[W-1:H]);
  end

  // Stage two: combine, drop fraction bits, clamp and restore the sign.
  always_comb begin
    full  = PW'(pl_r) + (PW'(phi_r) << H);
    q     = full >> F;
    lim   = PW'({1'b0, {(W-1){1'b1}}}) + PW'(neg_r);
    r     = (q > lim) ? lim[W-1:0] : q[W-1:0];
    p_nxt = neg_r ? (~r + 1'b1) : r;
  end

  always_ff @(posedge clk) begin
    pl_r  <= pl_nxt;
    phi_r <= phi_nxt;
    neg_r <= a[W-1] ^ b[W-1];
    p_r   <= p_nxt;
  end

  assign p = p_r;

endmodule

// ----- src/icb_front.sv -----
// Front end: accepts items, converts fields and registers to the internal word,
// and queues the converted commands. Depends on icb_pkg and icb_fifo.
`timescale 1ns / 1ps

module icb_front #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                push,
  output logic                                full,
  input  logic signed [icb_pkg::IN_W-1:0]     left_lin,
  input  logic signed [icb_pkg::IN_W-1:0]     left_quad,
  input  logic signed [icb_pkg::IN_W-1:0]     left_cube,
  input  logic signed [icb_pkg::IN_W-1:0]     right_lin,
  input  logic signed [icb_pkg::IN_W-1:0]     right_quad,
  input  logic signed [icb_pkg::IN_W-1:0]     right_cube,
  input  logic signed [icb_pkg::TGT_W-1:0]    goal_corr,
  input  logic [icb_pkg::CFG_W-1:0]           bracket_half,
  input  logic [icb_pkg::CFG_W-1:0]           corr_tol,
  input  logic [icb_pkg::LIM_W-1:0]           iter_limit,
  output logic                                cmd_valid,
  input  logic                                cmd_pop,
  output logic [icb_pkg::CMD_N-1:0][W-1:0]    cmd_data,
  output logic [icb_pkg::LIM_W-1:0]           cmd_limit
);

  import icb_pkg::*;

  localparam int SHL = (F >= IO_FRAC) ? F - IO_FRAC : 0;
  localparam int SHR = (F < IO_FRAC) ? IO_FRAC - F : 0;
  localparam int EXT = IN_W + SHL + W + 2;
  localparam int QW  = CMD_N * W + LIM_W;

  logic [CMD_N-1:0][W-1:0] conv;
  logic [QW-1:0]           q_in, q_out;
  logic                    q_empty;

  // Rescale a 24-fraction-bit value to the internal word, saturating.
  function automatic logic [W-1:0] to_int(input logic signed [IN_W-1:0] v);
    logic signed [EXT-1:0] x;
    logic [W-1:0]          res;
    x = EXT'(v);
    x = (x <<< SHL) >>> SHR;
    if (x[EXT-1:W-1] != {(EXT-W+1){x[EXT-1]}}) begin
      res = x[EXT-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      res = x[W-1:0];
    end
    return res;
  endfunction

  // Convert every field of the incoming item, plus the search registers.
  always_comb begin
    conv[CMD_LL]  = to_int(left_lin);
    conv[CMD_LQ]  = to_int(left_quad);
    conv[CMD_LC]  = to_int(left_cube);
    conv[CMD_RL]  = to_int(right_lin);
    conv[CMD_RQ]  = to_int(right_quad);
    conv[CMD_RC]  = to_int(right_cube);
    conv[CMD_TGT] = to_int(IN_W'(goal_corr));
    conv[CMD_BND] = to_int($signed({{(IN_W-CFG_W){1'b0}}, bracket_half}));
    conv[CMD_TOL] = to_int($signed({{(IN_W-CFG_W){1'b0}}, corr_tol}));
  end

  assign q_in = {iter_limit, conv};

  icb_fifo #(
    .WIDTH(QW),
    .DEPTH(2)
  ) u_cmd_q (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data(q_in),
    .full     (full),
    .pop      (cmd_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  assign cmd_valid = !q_empty;
  assign cmd_data  = q_out[CMD_N*W-1:0];
  assign cmd_limit = q_out[QW-1:CMD_N*W];

endmodule

// ----- src/icb_solver.sv -----
// Back end: bisection sequencer around one shared pipelined multiplier.
// Depends on icb_pkg and icb_mul.
`timescale 1ns / 1ps

module icb_solver #(
  parameter int W = 32,
  parameter int F = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cmd_valid,
  output logic                              cmd_pop,
  input  logic [icb_pkg::CMD_N-1:0][W-1:0]  cmd_data,
  input  logic [icb_pkg::LIM_W-1:0]         cmd_limit,
  input  logic                              res_full,
  output logic                              res_push,
  output icb_pkg::icb_result_t              res_data
);

  import icb_pkg::*;

  localparam int SW  = W + 5;
  localparam int SHL = (F >= IO_FRAC) ? F - IO_FRAC : 0;
  localparam int SHR = (F < IO_FRAC) ? IO_FRAC - F : 0;
  localparam int OW  = W + SHR + RHO_W;

  icb_state_t state_r, state_nxt;
  logic [PH_W-1:0] ph_r, ph_nxt;

  icb_kind_t kind_r;
  logic [LIM_W-1:0] lim_r, it_r;
  logic signed [W-1:0] ll_r, lq_r, lc_r, rl_r, rq_r, rc_r, tgt_r, bnd_r, tol_r;
  logic signed [W-1:0] pbb_r, pbd_r, pdb_r, pdd_r, pcc_r, lin_r;
  logic signed [W-1:0] lo_r, hi_r, x_r, flo_r, f_r;
  logic signed [W-1:0] sq_r, tlin_r, tcc_r, res_r;
  logic status_r, limit_r;

  logic signed [W-1:0] mul_a, mul_b, mul_p;
  logic signed [SW-1:0] lin_sum, f_sum;
  logic signed [W:0] mid_sum, gap;
  logic signed [W-1:0] mid;
  logic same_lo_f, flo_small, f_small, gap_small, hi_stop, mid_stop, more_iter;
  logic signed [OW-1:0] rho_ext;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if (v[SW-1:W-1] != {(SW-W+1){v[SW-1]}}) begin
      r = v[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // Both strictly positive or both strictly negative.
  function automatic logic same_sign(input logic signed [W-1:0] a,
                                     input logic signed [W-1:0] b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  function automatic logic mag_le(input logic signed [W-1:0] a,
                                  input logic signed [W-1:0] t);
    logic [W-1:0] m;
    m = a[W-1] ? (~a + 1'b1) : a;
    return m <= t;
  endfunction

  icb_mul #(
    .W(W),
    .F(F)
  ) u_mul (
    .clk(clk),
    .a  (mul_a),
    .b  (mul_b),
    .p  (mul_p)
  );

  // Sums, midpoint and stop tests.
  always_comb begin
    lin_sum = SW'(pbb_r) + (SW'(pbd_r) <<< 1) + SW'(pbd_r)
            + (SW'(pdb_r) <<< 1) + SW'(pdb_r)
            + (SW'(pdd_r) <<< 3) + SW'(pdd_r);
    f_sum   = SW'(tlin_r) + (SW'(tcc_r) <<< 1)
            + (SW'(mul_p) <<< 2) + (SW'(mul_p) <<< 1) - SW'(tgt_r);
    mid_sum = (W+1)'(lo_r) + (W+1)'(hi_r);
    mid     = mid_sum[W:1];
    gap     = (W+1)'(hi_r) - (W+1)'(lo_r);
    same_lo_f = same_sign(flo_r, f_r);
    flo_small = mag_le(flo_r, tol_r);
    f_small   = mag_le(f_r, tol_r);
    gap_small = (gap <= (W+1)'(tol_r));
    hi_stop   = same_lo_f || flo_small || f_small;
    mid_stop  = f_small || gap_small;
    more_iter = (it_r < lim_r);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (cmd_valid) state_nxt = ST_PREP;
      ST_PREP: if (ph_r == PH_LAST) state_nxt = ST_LIN;
      ST_LIN:  state_nxt = ST_EVAL;
      ST_EVAL: if (ph_r == PH_LAST) state_nxt = ST_POST;
      ST_POST: begin
        unique case (kind_r)
          KIND_LO:  state_nxt = ST_EVAL;
          KIND_HI:  state_nxt = hi_stop ? ST_DONE : ST_ITER;
          KIND_MID: state_nxt = mid_stop ? ST_DONE : ST_ITER;
          default:  state_nxt = ST_DONE;
        endcase
      end
      ST_ITER: state_nxt = more_iter ? ST_EVAL : ST_DONE;
      ST_DONE: if (!res_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: handshakes and multiplier operand selection.
  always_comb begin
    cmd_pop  = 1'b0;
    res_push = 1'b0;
    mul_a    = x_r;
    mul_b    = x_r;
    unique case (state_r)
      ST_IDLE: cmd_pop = cmd_valid;
      ST_PREP: begin
        case (ph_r)
          3'd0:    begin mul_a = ll_r; mul_b = rl_r; end
          3'd1:    begin mul_a = ll_r; mul_b = rc_r; end
          3'd2:    begin mul_a = lc_r; mul_b = rl_r; end
          3'd3:    begin mul_a = lc_r; mul_b = rc_r; end
          3'd4:    begin mul_a = lq_r; mul_b = rq_r; end
          default: begin mul_a = x_r;  mul_b = x_r;  end
        endcase
      end
      ST_EVAL: begin
        case (ph_r)
          3'd1:    begin mul_a = x_r;   mul_b = lin_r; end
          3'd2:    begin mul_a = mul_p; mul_b = x_r;   end
          3'd3:    begin mul_a = pcc_r; mul_b = sq_r;  end
          3'd4:    begin mul_a = pdd_r; mul_b = mul_p; end
          default: begin mul_a = x_r;   mul_b = x_r;   end
        endcase
      end
      ST_DONE: res_push = !res_full;
      ST_LIN, ST_POST, ST_ITER: begin
        mul_a = x_r;
        mul_b = x_r;
      end
      default: begin
        mul_a = x_r;
        mul_b = x_r;
      end
    endcase
  end

  // Phase counter runs through the multiply schedules.
  always_comb begin
    if ((state_r == ST_PREP || state_r == ST_EVAL) && ph_r != PH_LAST) begin
      ph_nxt = ph_r + 1'b1;
    end else begin
      ph_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          ll_r     <= cmd_data[CMD_LL];
          lq_r     <= cmd_data[CMD_LQ];
          lc_r     <= cmd_data[CMD_LC];
          rl_r     <= cmd_data[CMD_RL];
          rq_r     <= cmd_data[CMD_RQ];
          rc_r     <= cmd_data[CMD_RC];
          tgt_r    <= cmd_data[CMD_TGT];
          bnd_r    <= cmd_data[CMD_BND];
          tol_r    <= cmd_data[CMD_TOL];
          lim_r    <= cmd_limit;
          status_r <= 1'b0;
          limit_r  <= 1'b0;
        end
      end
      ST_PREP: begin
        case (ph_r)
          3'd2:    pbb_r <= mul_p;
          3'd3:    pbd_r <= mul_p;
          3'd4:    pdb_r <= mul_p;
          3'd5:    pdd_r <= mul_p;
          3'd6:    pcc_r <= mul_p;
          default: ;
        endcase
      end
      ST_LIN: begin
        lin_r  <= sat_w(lin_sum);
        lo_r   <= -bnd_r;
        hi_r   <= bnd_r;
        x_r    <= -bnd_r;
        kind_r <= KIND_LO;
      end
      ST_EVAL: begin
        case (ph_r)
          3'd2:    sq_r   <= mul_p;
          3'd3:    tlin_r <= mul_p;
          3'd5:    tcc_r  <= mul_p;
          3'd6:    f_r    <= sat_w(f_sum);
          default: ;
        endcase
      end
      ST_POST: begin
        case (kind_r)
          KIND_LO: begin
            flo_r  <= f_r;
            x_r    <= hi_r;
            kind_r <= KIND_HI;
          end
          KIND_HI: begin
            it_r <= '0;
            if (same_lo_f) begin
              status_r <= 1'b1;
              res_r    <= '0;
            end else if (flo_small) begin
              res_r <= lo_r;
            end else if (f_small) begin
              res_r <= hi_r;
            end
          end
          default: begin
            it_r <= it_r + 1'b1;
            if (mid_stop) begin
              res_r <= x_r;
            end else if (!same_lo_f) begin
              hi_r <= x_r;
            end else begin
              lo_r  <= x_r;
              flo_r <= f_r;
            end
          end
        endcase
      end
      ST_ITER: begin
        if (more_iter) begin
          x_r    <= mid;
          kind_r <= KIND_MID;
        end else begin
          res_r   <= mid;
          limit_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Back to 24 fraction bits, flooring.
  always_comb begin
    rho_ext = (OW'(res_r) <<< SHR) >>> SHL;
    res_data.rho           = rho_ext[RHO_W-1:0];
    res_data.status        = status_r;
    res_data.limit_reached = limit_r;
  end

endmodule

// ----- src/icb_checker.sv -----
// Port-level checks for the intermediate correlation bisection unit, bound to
// the top level. Depends on icb_pkg and intermediate_correlation_bisection_unit.
`timescale 1ns / 1ps

module icb_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_push,
  input logic                             in_full,
  input logic                             out_empty,
  input logic                             out_pop,
  input logic signed [icb_pkg::RHO_W-1:0] out_rho,
  input logic                             out_status,
  input logic                             out_limit_reached
);

  // Reset leaves both queues empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // A no-root item reports zero rho and no limit flag.
  a_no_root_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_status |-> out_rho == '0 && !out_limit_reached)
    else $error("no-root item carries a value");

  // A waiting item holds until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_rho)
      && $stable(out_status) && $stable(out_limit_reached))
    else $error("waiting item changed");

  // The front queue only fills when an item arrives.
  a_full_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    !in_full && !in_push |=> !in_full)
    else $error("front queue filled without an item");

endmodule

bind intermediate_correlation_bisection_unit icb_checker u_icb_checker (.*);

// ----- sim/icb_solution_checker.sv -----
// Checker for the intermediate correlation bisection unit: watches the input,
// result and register ports, predicts each solution and compares it.
// Depends on icb_pkg for widths, register indexes, reset values and icb_result_t.
`timescale 1ns / 1ps

module icb_solution_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic                              in_full,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_lin,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_quad,
  input  logic signed [icb_pkg::IN_W-1:0]   in_left_cube,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_lin,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_quad,
  input  logic signed [icb_pkg::IN_W-1:0]   in_right_cube,
  input  logic signed [icb_pkg::TGT_W-1:0]  in_goal_corr,
  input  logic                              out_empty,
  input  logic                              out_pop,
  input  logic signed [icb_pkg::RHO_W-1:0]  out_rho,
  input  logic                              out_status,
  input  logic                              out_limit_reached,
  input  logic                              cfg_we,
  input  logic [icb_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [icb_pkg::CFG_W-1:0]         cfg_data,
  output int                                mismatch_count,
  output int                                results_owed
);
  import icb_pkg::*;

  // The block runs at its default word format: 32-bit words with 24 fraction
  // bits, the same as the ports, so inputs enter and rho leaves unchanged.
  localparam int     FRAC     = 24;
  localparam longint WORD_MAX = 64'sd2147483647;

  logic [CFG_W-1:0] cfg_bound;
  logic [CFG_W-1:0] cfg_tol;
  logic [LIM_W-1:0] cfg_limit;

  icb_result_t expected_solutions[$];
  icb_result_t want;
  int          result_no;

  function automatic longint sat_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < -WORD_MAX - 1) return -WORD_MAX - 1;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic bit same_sign(longint a, longint b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  // Fixed-point product: magnitudes multiplied exactly, fraction bits dropped
  // (toward zero), sign restored, then clipped to the signed word.
  function automatic longint sat_product(longint x, longint y);
    logic [63:0] full_prod;
    logic [63:0] ceiling;
    bit          neg;
    neg = (x < 0) != (y < 0);
    full_prod = mag(x) * mag(y);
    full_prod = full_prod >> FRAC;
    ceiling = WORD_MAX + (neg ? 1 : 0);
    if (full_prod > ceiling) full_prod = ceiling;
    return neg ? -longint'(full_prod) : longint'(full_prod);
  endfunction

  // Covariance cubic minus the target, evaluated at rho.
  function automatic longint fit_error(longint lin, longint p_cc, longint p_dd,
                                       longint target, longint rho);
    longint sq;
    longint cube;
    sq = sat_product(rho, rho);
    cube = sat_product(sq, rho);
    return sat_word(sat_product(rho, lin) + 2 * sat_product(p_cc, sq)
                    + 6 * sat_product(p_dd, cube) - target);
  endfunction

  // Bisection for the normal correlation that gives the target correlation.
  function automatic icb_result_t solve_correlation(
      longint ll, longint lq, longint lc, longint rl, longint rq, longint rc,
      longint target, longint bound, longint tol, int unsigned lim);
    icb_result_t sol;
    longint      p_bb, p_bd, p_db, p_dd, p_cc, lin;
    longint      lo, hi, flo, fhi, mid, fmid, res;
    bit          done;
    bit          no_root;
    bit          hit_limit;
    int unsigned pass_no;
    p_bb = sat_product(ll, rl);
    p_bd = sat_product(ll, rc);
    p_db = sat_product(lc, rl);
    p_dd = sat_product(lc, rc);
    p_cc = sat_product(lq, rq);
    lin = sat_word(p_bb + 3 * p_bd + 3 * p_db + 9 * p_dd);
    lo = -bound;
    hi = bound;
    flo = fit_error(lin, p_cc, p_dd, target, lo);
    fhi = fit_error(lin, p_cc, p_dd, target, hi);
    res = 0;
    done = 1'b0;
    no_root = 1'b0;
    hit_limit = 1'b0;

    // A zero at either end counts as a sign change; an end within the
    // tolerance is taken directly.
    if (same_sign(flo, fhi)) begin
      no_root = 1'b1;
      done = 1'b1;
    end else if (mag(flo) <= tol) begin
      res = lo;
      done = 1'b1;
    end else if (mag(fhi) <= tol) begin
      res = hi;
      done = 1'b1;
    end

    for (pass_no = 0; !done && pass_no < lim; pass_no++) begin
      mid = (lo + hi) >>> 1;
      fmid = fit_error(lin, p_cc, p_dd, target, mid);
      if (mag(fmid) <= tol || mag(hi - lo) <= tol) begin
        res = mid;
        done = 1'b1;
      end else if (!same_sign(flo, fmid)) begin
        hi = mid;
      end else begin
        lo = mid;
        flo = fmid;
      end
    end

    // Out of steps: report the midpoint of what is left of the bracket.
    if (!done) begin
      res = (lo + hi) >>> 1;
      hit_limit = 1'b1;
    end
    sol.rho = res[RHO_W-1:0];
    sol.status = no_root;
    sol.limit_reached = hit_limit;
    return sol;
  endfunction

  task automatic report_mismatch(string field, longint expected_val, longint got_val);
    $display("MISMATCH on result %0d, %s: expected %0d, got %0d",
             result_no, field, expected_val, got_val);
    mismatch_count++;
  endtask

  // Everything is sampled at the rising edge, before the block's own updates.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg_bound = BRACKET_RST;
      cfg_tol = CORR_TOL_RST;
      cfg_limit = ITER_LIM_RST;
      expected_solutions.delete();
      results_owed <= 0;
    end else begin
      if (cfg_we === 1'b1) begin
        case (cfg_index)
          REG_BRACKET:  cfg_bound = cfg_data;
          REG_CORR_TOL: cfg_tol = cfg_data;
          REG_ITER_LIM: cfg_limit = cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end

      if (in_push === 1'b1 && in_full === 1'b0) begin
        expected_solutions.insert(expected_solutions.size(), solve_correlation(
          longint'(in_left_lin), longint'(in_left_quad), longint'(in_left_cube),
          longint'(in_right_lin), longint'(in_right_quad), longint'(in_right_cube),
          longint'(in_goal_corr), longint'(cfg_bound), longint'(cfg_tol),
          int'(cfg_limit)));
      end

      if (out_pop === 1'b1 && out_empty === 1'b0) begin
        if (expected_solutions.size() == 0) begin
          report_mismatch("unexpected result rho", 0, longint'(out_rho));
        end else begin
          want = expected_solutions.pop_front();
          if (out_rho !== want.rho)
            report_mismatch("rho", longint'(want.rho), longint'(out_rho));
          if (out_status !== want.status)
            report_mismatch("status", longint'(want.status), longint'(out_status));
          if (out_limit_reached !== want.limit_reached)
            report_mismatch("limit_reached", longint'(want.limit_reached),
                            longint'(out_limit_reached));
        end
        result_no++;
      end
      results_owed <= expected_solutions.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the intermediate correlation bisection unit: clock, reset,
// item and register stimulus with random gaps, and the verdict.
// Depends on icb_pkg, the unit itself and icb_solution_checker.
`timescale 1ns / 1ps

module tb;
  import icb_pkg::*;

  localparam int Q_ONE       = 16777216;
  localparam int Q_HALF      = 8388608;
  localparam int TGT_MAX     = 16777215;
  localparam int BOUND_RST   = 16609444;
  localparam int HOLD_CYCLES = 400;
  localparam logic signed [IN_W-1:0] W_MAX = 32'sh7fffffff;
  localparam logic signed [IN_W-1:0] W_MIN = 32'sh80000000;

  logic                     clk;
  logic                     rst_n;
  logic                     in_push;
  logic                     in_full;
  logic signed [IN_W-1:0]   in_left_lin;
  logic signed [IN_W-1:0]   in_left_quad;
  logic signed [IN_W-1:0]   in_left_cube;
  logic signed [IN_W-1:0]   in_right_lin;
  logic signed [IN_W-1:0]   in_right_quad;
  logic signed [IN_W-1:0]   in_right_cube;
  logic signed [TGT_W-1:0]  in_goal_corr;
  logic                     out_empty;
  logic                     out_pop;
  logic signed [RHO_W-1:0]  out_rho;
  logic                     out_status;
  logic                     out_limit_reached;
  logic                     cfg_we;
  logic [CIDX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]         cfg_data;

  int mismatch_count;
  int results_owed;
  int tx_calm;
  int rx_calm;
  bit hold_request;

  intermediate_correlation_bisection_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_left_lin       (in_left_lin),
    .in_left_quad      (in_left_quad),
    .in_left_cube      (in_left_cube),
    .in_right_lin      (in_right_lin),
    .in_right_quad     (in_right_quad),
    .in_right_cube     (in_right_cube),
    .in_goal_corr      (in_goal_corr),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_rho           (out_rho),
    .out_status        (out_status),
    .out_limit_reached (out_limit_reached),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  icb_solution_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_left_lin       (in_left_lin),
    .in_left_quad      (in_left_quad),
    .in_left_cube      (in_left_cube),
    .in_right_lin      (in_right_lin),
    .in_right_quad     (in_right_quad),
    .in_right_cube     (in_right_cube),
    .in_goal_corr      (in_goal_corr),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_rho           (out_rho),
    .out_status        (out_status),
    .out_limit_reached (out_limit_reached),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .mismatch_count    (mismatch_count),
    .results_owed      (results_owed)
  );

  // Free-running clock, 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle length before the next handshake: mostly none or short, a few long,
  // and now and then a calm stretch with no idling at all.
  function automatic int pick_gap(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int rand_span(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Linear coefficient of a typical Fleishman cubic, occasionally negated.
  function automatic int fleish_lin();
    int b;
    b = int'($urandom_range(5033165, 20132659));
    if ($urandom_range(0, 9) == 0) b = -b;
    return b;
  endfunction

  // Offer one item after a random gap and hold it until it is accepted.
  task automatic offer_item(input logic signed [IN_W-1:0] ll, lq, lc, rl, rq, rc,
                            input int tgt);
    int gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk);
      in_push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_left_lin <= ll;
    in_left_quad <= lq;
    in_left_cube <= lc;
    in_right_lin <= rl;
    in_right_quad <= rq;
    in_right_cube <= rc;
    in_goal_corr <= tgt[TGT_W-1:0];
    in_push <= 1'b1;
    do @(posedge clk); while (in_full !== 1'b0);
  endtask

  // Mostly realistic Fleishman coefficients so the search goes deep; the rest
  // are moderate values and raw words that drive the products into saturation.
  task automatic offer_random_item();
    int                     style;
    int                     t;
    logic signed [IN_W-1:0] c[6];
    style = $urandom_range(0, 99);
    if (style < 65) begin
      c[0] = fleish_lin();
      c[1] = rand_span(6710886);
      c[2] = int'($urandom_range(0, 6710886)) - 2516582;
      c[3] = fleish_lin();
      c[4] = rand_span(6710886);
      c[5] = int'($urandom_range(0, 6710886)) - 2516582;
      t = ($urandom_range(0, 9) < 7) ? rand_span(15099494) : rand_span(TGT_MAX);
    end else if (style < 80) begin
      foreach (c[k]) c[k] = rand_span(1 << 26);
      t = rand_span(TGT_MAX);
    end else begin
      foreach (c[k]) c[k] = $urandom();
      t = rand_span(TGT_MAX);
    end
    offer_item(c[0], c[1], c[2], c[3], c[4], c[5], t);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every predicted result has come back.
  task automatic settle_results();
    @(negedge clk);
    in_push <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] bound, input logic [CFG_W-1:0] tol,
                           input logic [LIM_W-1:0] lim, input int count, input bit hold);
    settle_results();
    write_reg(REG_BRACKET, bound);
    write_reg(REG_CORR_TOL, tol);
    write_reg(REG_ITER_LIM, {{(CFG_W - LIM_W){1'b0}}, lim});
    hold_request = hold;
    repeat (count) offer_random_item();
  endtask

  // Result side: random pop gaps, plus a long hold-off when one is requested
  // so that both queues fill and the input stalls.
  initial begin : result_drain
    int gap;
    int hold_left;
    out_pop = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk);
        out_pop <= 1'b0;
        for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) @(negedge clk);
      end
      gap = pick_gap(rx_calm);
      if (gap > 0) begin
        @(negedge clk);
        out_pop <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_pop <= 1'b1;
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] pick_bound;
    logic [CFG_W-1:0] pick_tol;
    logic [LIM_W-1:0] pick_limit;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_left_lin = '0;
    in_left_quad = '0;
    in_left_cube = '0;
    in_right_lin = '0;
    in_right_quad = '0;
    in_right_cube = '0;
    in_goal_corr = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings.
    // Flat zero residual: the low end is taken at once.
    offer_item(0, 0, 0, 0, 0, 0, 0);
    // Identity cubic with the target on either end of the bracket.
    offer_item(Q_ONE, 0, 0, Q_ONE, 0, 0, BOUND_RST);
    offer_item(Q_ONE, 0, 0, Q_ONE, 0, 0, -BOUND_RST);
    offer_item(Q_ONE, 0, 0, Q_ONE, 0, 0, 0);
    // Targets past what the cubic reaches: no sign change.
    offer_item(Q_ONE, 0, 0, Q_ONE, 0, 0, TGT_MAX);
    offer_item(Q_ONE, 0, 0, Q_ONE, 0, 0, -TGT_MAX);
    // Decreasing cubic.
    offer_item(-Q_ONE, 0, 0, Q_ONE, 0, 0, Q_HALF);
    // Even cubics, same sign at both ends.
    offer_item(0, Q_ONE, 0, 0, Q_ONE, 0, 0);
    offer_item(0, Q_ONE, 0, 0, -Q_ONE, 0, -Q_HALF);
    // Cubic terms only.
    offer_item(0, 0, Q_HALF, 0, 0, Q_HALF, Q_HALF);
    // Word extremes, every product saturating.
    offer_item(W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0);
    offer_item(W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, TGT_MAX);
    offer_item(W_MAX, W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, -TGT_MAX);
    offer_item(32'sh55555555, 32'sh55555555, 32'sh55555555, 32'sh55555555,
               32'sh55555555, 32'sh55555555, 11184810);
    offer_item(32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'shAAAAAAAA,
               32'shAAAAAAAA, 32'shAAAAAAAA, -11184810);
    // Typical Fleishman pairs.
    offer_item(15099494, 1677722, 503316, 15099494, 1677722, 503316, Q_HALF);
    offer_item(15099494, 1677722, 503316, 15099494, 1677722, 503316, -11744051);
    offer_item(15099494, 1677722, 503316, 15099494, 1677722, 503316, 15938355);
    offer_item(18454938, -3355443, -838861, 15099494, 1677722, 503316, 5033165);
    offer_item(18454938, -3355443, -838861, 18454938, -3355443, -838861, -TGT_MAX);

    repeat (280) offer_random_item();

    // Widest bracket, finest nonzero tolerance, most steps.
    run_phase(24'hFFFFFF, 24'd1, 8'd255, 110, 1'b0);
    // Narrowest bracket.
    run_phase(24'd1, CORR_TOL_RST, ITER_LIM_RST, 80, 1'b0);
    // Zero tolerance: only an exact zero, an empty bracket or no sign change stops early.
    run_phase(24'h800000, 24'd0, 8'd40, 140, 1'b0);
    // Widest tolerance with a single step; the result side holds off here.
    run_phase(24'hFFFFFF, 24'hFFFFFF, 8'd1, 120, 1'b1);
    // Zero bound collapses the bracket.
    run_phase(24'd0, CORR_TOL_RST, ITER_LIM_RST, 30, 1'b1);
    // Zero step limit returns the midpoint at once.
    run_phase(BRACKET_RST, CORR_TOL_RST, 8'd0, 30, 1'b0);

    // Random settings, mostly with a small tolerance.
    repeat (6) begin
      pick_bound = CFG_W'($urandom_range(1, 16777215));
      pick_tol = CFG_W'(($urandom_range(0, 9) < 7) ? $urandom_range(1, 4096)
                                                   : $urandom_range(1, 16777215));
      pick_limit = LIM_W'($urandom_range(1, 64));
      run_phase(pick_bound, pick_tol, pick_limit, 90, 1'b0);
    end

    settle_results();
    repeat (300) @(negedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #80_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
